// ===== rtl/core/pctmr_pkg.sv =====
// Package for the four-channel periodic compare timer.
// Holds widths, register index codes and the shared types.
// No dependencies; every other file of the timer imports it.
package pctmr_pkg;

   localparam int NUM_CHANNELS   = 4;
   localparam int COUNT_BITS     = 16;
   localparam int CHAN_BITS      = $clog2(NUM_CHANNELS);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [COUNT_BITS-1:0]     count_type;
   typedef logic [NUM_CHANNELS-1:0]   chan_mask_type;
   typedef logic [CHAN_BITS-1:0]      chan_index_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   // Register index codes of the configuration port.
   localparam csr_index_type REG_PRESCALE = 3'd0;
   localparam csr_index_type REG_STEP_CH0 = 3'd1;
   localparam csr_index_type REG_STEP_CH3 = 3'd4;
   localparam csr_index_type REG_ENABLE   = 3'd5;

   localparam count_type     COUNT_ALL_ONES = 16'hffff;
   localparam chan_mask_type CHAN_ONE       = 4'b0001;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      count_type                       prescale_minus_one;
      logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] step;
      chan_mask_type                   enable;
   } csr_regs_type;

   // Per-channel control for one accepted transaction or register write.
   typedef struct packed {
      logic advance;  // counter moved to a new value in this transaction
      logic clear;    // write-one-to-clear bit, already qualified by accept
      logic enable;   // auto advance enabled
      logic load;     // step register of this channel is being written
   } chan_ctl_type;

endpackage

// ===== rtl/core/pctmr_if.sv =====
// Valid/ready channel interfaces of the compare timer: request, response and
// register write. Depends on pctmr_pkg.
interface pctmr_req_if import pctmr_pkg::*; ();
   logic          valid;
   logic          ready;
   logic          tick;
   chan_mask_type flag_clear;

   modport source (output valid, output tick, output flag_clear, input ready);
   modport sink   (input valid, input tick, input flag_clear, output ready);
endinterface

interface pctmr_rsp_if import pctmr_pkg::*; ();
   logic          valid;
   logic          ready;
   count_type     count_value;
   chan_mask_type match_flags;
   logic          irq;
   count_type     compare_ch0;
   count_type     compare_ch1;
   count_type     compare_ch2;
   count_type     compare_ch3;

   modport source (output valid, output count_value, output match_flags, output irq,
                   output compare_ch0, output compare_ch1, output compare_ch2,
                   output compare_ch3, input ready);
   modport sink   (input valid, input count_value, input match_flags, input irq,
                   input compare_ch0, input compare_ch1, input compare_ch2,
                   input compare_ch3, output ready);
endinterface

interface pctmr_csr_if import pctmr_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pctmr_csr.sv =====
// Configuration register file of the compare timer: prescaler, steps, enables.
// Depends on pctmr_pkg and pctmr_csr_if.
module pctmr_csr import pctmr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   pctmr_csr_if.sink          csr_bus,
   output csr_regs_type       regs,
   output chan_mask_type      step_load,
   output count_type          load_value
);

   csr_regs_type   regs_ff, regs_in;
   chan_index_type slot;

   assign csr_bus.ready = 1'b1;
   assign slot          = chan_index_type'(csr_bus.index - REG_STEP_CH0);
   assign load_value    = count_type'(csr_bus.data);
   assign regs          = regs_ff;

   always_comb begin
      regs_in   = regs_ff;
      step_load = '0;
      if (csr_bus.valid) begin
         unique case (csr_bus.index) inside
            REG_PRESCALE: begin
               regs_in.prescale_minus_one = count_type'(csr_bus.data);
            end
            [REG_STEP_CH0:REG_STEP_CH3]: begin
               step_load            = CHAN_ONE << slot;
               regs_in.step[slot]   = count_type'(csr_bus.data);
            end
            REG_ENABLE: begin
               regs_in.enable = chan_mask_type'(csr_bus.data);
            end
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.prescale_minus_one <= '0;
         regs_ff.step               <= {NUM_CHANNELS{COUNT_ALL_ONES}};
         regs_ff.enable             <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== rtl/core/pctmr_channel.sv =====
// One compare channel: compare value, match flag and auto advance.
// Depends on pctmr_pkg.
module pctmr_channel import pctmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  chan_ctl_type ctl,
   input  count_type    count_next,
   input  count_type    step,
   input  count_type    load_value,
   output count_type    compare,
   output logic         flag
);

   count_type compare_ff, compare_in;
   logic      flag_ff, flag_in;
   logic      match;

   // A match is only seen when the counter steps onto the compare value.
   assign match = ctl.advance && (count_next == compare_ff);

   always_comb begin
      flag_in    = (flag_ff & ~ctl.clear) | match;
      compare_in = compare_ff;
      if (ctl.load) begin
         compare_in = load_value;
      end else if (match && ctl.enable) begin
         compare_in = count_type'(compare_ff + step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_ff <= COUNT_ALL_ONES;
         flag_ff    <= 1'b0;
      end else begin
         compare_ff <= compare_in;
         flag_ff    <= flag_in;
      end
   end

   assign compare = compare_ff;
   assign flag    = flag_ff;

endmodule

// ===== rtl/core/four_channel_periodic_compare_timer.sv =====
// Top level of the four-channel periodic compare timer: prescaler, counter,
// channel instances and response handshake.
// Depends on pctmr_pkg, pctmr_if, pctmr_csr and pctmr_channel.
//
//   Channel   Direction  Handshake      Payload
//   req_bus   in         valid/ready    tick, flag_clear
//   rsp_bus   out        valid/ready    count_value, match_flags, irq, compare_ch0..3
//   csr_bus   in         valid/ready    index, data (register write)
//
// Each request yields one response in the next cycle, and a new request is taken
// every cycle while the response side keeps up. The prescaler, counter, compare
// values and flags are themselves the response register, so a response shows
// the state its request left behind. While a response waits on rsp_bus.ready,
// req_bus.ready drops and the counter state holds; register writes still land.
// Synchronous active-high reset clears the counters and flags, sets the compare
// values and steps to all ones; csr_bus never stalls.
module four_channel_periodic_compare_timer import pctmr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pctmr_req_if.sink   req_bus,
   pctmr_rsp_if.source rsp_bus,
   pctmr_csr_if.sink   csr_bus
);

   csr_regs_type  regs;
   chan_mask_type step_load;
   count_type     load_value;

   count_type     prescale_count_ff, prescale_count_in;
   count_type     timer_count_ff, timer_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_accept;
   logic          advance;

   count_type     compare [NUM_CHANNELS];
   chan_mask_type flags;

   pctmr_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_bus    (csr_bus),
      .regs       (regs),
      .step_load  (step_load),
      .load_value (load_value)
   );

   // A new transaction may enter when no response is pending or the pending
   // one is being taken in this same cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   // The prescaler expires when its count has reached the reload value; a
   // count left above a lowered reload value also counts as expired.
   always_comb begin
      prescale_count_in = prescale_count_ff;
      timer_count_in    = timer_count_ff;
      advance           = 1'b0;
      if (req_accept && req_bus.tick) begin
         if (prescale_count_ff >= regs.prescale_minus_one) begin
            prescale_count_in = '0;
            timer_count_in    = count_type'(timer_count_ff + 1'b1);
            advance           = 1'b1;
         end else begin
            prescale_count_in = count_type'(prescale_count_ff + 1'b1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_count_ff <= '0;
         timer_count_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         prescale_count_ff <= prescale_count_in;
         timer_count_ff    <= timer_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Each channel compares against the counter's new value; the clear mask is
   // applied before a match in the same transaction, so a match wins.
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
      chan_ctl_type ctl;

      assign ctl.advance = advance;
      assign ctl.clear   = req_accept && req_bus.flag_clear[i];
      assign ctl.enable  = regs.enable[i];
      assign ctl.load    = step_load[i];

      pctmr_channel u_channel (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .count_next (timer_count_in),
         .step       (regs.step[i]),
         .load_value (load_value),
         .compare    (compare[i]),
         .flag       (flags[i])
      );
   end

   // State only changes on an accepted transaction or a register write; the user
   // must write only while no response is pending, which the block does not enforce,
   // so that the state registers hold the pending response stable.
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.count_value = timer_count_ff;
   assign rsp_bus.match_flags = flags;
   assign rsp_bus.irq         = |(flags & regs.enable);
   assign rsp_bus.compare_ch0 = compare[0];
   assign rsp_bus.compare_ch1 = compare[1];
   assign rsp_bus.compare_ch2 = compare[2];
   assign rsp_bus.compare_ch3 = compare[3];

endmodule

// ===== rtl/core/pctmr_checker.sv =====
// Port-level checks for the compare timer, bound onto the top level.
// Depends on pctmr_pkg and the channel interfaces.
module pctmr_checker import pctmr_pkg::*; (
   input logic         clock,
   input logic         reset,
   pctmr_req_if.sink   req_bus,
   pctmr_rsp_if.source rsp_bus
);

   logic req_accept;

   assign req_accept = req_bus.valid && req_bus.ready;

   // A stalled response keeps its count value and match flags.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.count_value) && $stable(rsp_bus.match_flags))
      else $error("response changed while stalled");

   // Every accepted request yields a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_bus.valid)
      else $error("no response after accepted request");

   // Without a tick the counter holds.
   a_no_tick_hold: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_bus.tick |=> rsp_bus.count_value == $past(rsp_bus.count_value))
      else $error("counter moved without a tick");

   // Without a tick, cleared flags stay cleared.
   a_clear_works: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_bus.tick |=> (rsp_bus.match_flags & $past(req_bus.flag_clear)) == '0)
      else $error("flag survived its clear");

   // The interrupt needs at least one pending flag.
   a_irq_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.irq |-> rsp_bus.match_flags != '0)
      else $error("interrupt without pending flag");

endmodule

bind four_channel_periodic_compare_timer pctmr_checker u_pctmr_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

// ===== test/compare_timer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the four-channel periodic compare timer: watches the request, response and
// register channels, predicts every response and compares it field by field.
// Depends on pctmr_pkg and the channel interfaces in pctmr_if.
module compare_timer_checker import pctmr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pctmr_req_if      req_bus,
   pctmr_rsp_if      rsp_bus,
   pctmr_csr_if      csr_bus,
   output int        error_count,
   output int        pending_count,
   output int        checked_count,
   output int        match_count,
   output int        irq_count,
   output count_type predicted_count
);

   typedef struct packed {
      count_type                               count_value;
      chan_mask_type                           match_flags;
      logic                                    irq;
      logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] compare;
   } timer_status_type;

   timer_status_type expected_status[$];

   // Shadow copy of the registers and of the timer state.
   count_type     prescale_reload;
   count_type     channel_step[NUM_CHANNELS];
   chan_mask_type channel_enable;
   count_type     prescale_count;
   count_type     timer_count;
   count_type     compare_value[NUM_CHANNELS];
   chan_mask_type pending_flags;

   // Advances the shadow state by one request and returns the status it leaves behind.
   function automatic timer_status_type next_timer_status(input logic tick_in,
                                                          input chan_mask_type clear_in);
      timer_status_type status;
      pending_flags &= ~clear_in;
      if (tick_in) begin
         if (prescale_count >= prescale_reload) begin
            prescale_count = '0;
            timer_count++;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
               if (timer_count == compare_value[ch]) begin
                  pending_flags[ch] = 1'b1;
                  match_count++;
                  if (channel_enable[ch]) begin
                     compare_value[ch] += channel_step[ch];
                  end
               end
            end
         end else begin
            prescale_count++;
         end
      end
      status.count_value = timer_count;
      status.match_flags = pending_flags;
      status.irq         = |(pending_flags & channel_enable);
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         status.compare[ch] = compare_value[ch];
      end
      return status;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      timer_status_type want;
      if (reset) begin
         prescale_reload = '0;
         channel_enable  = '0;
         prescale_count  = '0;
         timer_count     = '0;
         pending_flags   = '0;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            channel_step[ch]  = COUNT_ALL_ONES;
            compare_value[ch] = COUNT_ALL_ONES;
         end
         expected_status.delete();
      end else begin
         // Writes to the unused indexes fall through every branch and change nothing.
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == REG_PRESCALE) begin
               prescale_reload = csr_bus.data;
            end else if (csr_bus.index >= REG_STEP_CH0 && csr_bus.index <= REG_STEP_CH3) begin
               channel_step[csr_bus.index - REG_STEP_CH0]  = csr_bus.data;
               compare_value[csr_bus.index - REG_STEP_CH0] = csr_bus.data;
            end else if (csr_bus.index == REG_ENABLE) begin
               channel_enable = csr_bus.data[NUM_CHANNELS-1:0];
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status.size() == 0) begin
               error_count++;
               $error("Response transaction arrived with no request outstanding");
            end else begin
               want = expected_status.pop_front();
               check_field("count_value", 32'(want.count_value), 32'(rsp_bus.count_value));
               check_field("match_flags", 32'(want.match_flags), 32'(rsp_bus.match_flags));
               check_field("irq", 32'(want.irq), 32'(rsp_bus.irq));
               check_field("compare_ch0", 32'(want.compare[0]), 32'(rsp_bus.compare_ch0));
               check_field("compare_ch1", 32'(want.compare[1]), 32'(rsp_bus.compare_ch1));
               check_field("compare_ch2", 32'(want.compare[2]), 32'(rsp_bus.compare_ch2));
               check_field("compare_ch3", 32'(want.compare[3]), 32'(rsp_bus.compare_ch3));
               checked_count++;
               if (want.irq) begin
                  irq_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_status.push_back(next_timer_status(req_bus.tick, req_bus.flag_clear));
         end
      end
      pending_count   = expected_status.size();
      predicted_count = timer_count;
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the compare timer testbench: clock, reset, stimulus, response back-pressure,
// watchdog and verdict. Depends on pctmr_pkg, pctmr_if, the timer RTL and the checker.
module testbench;
   import pctmr_pkg::*;

   localparam int RANDOM_ITEMS    = 1860;
   localparam int FINAL_ITEMS     = 72;
   localparam int GAP_MAX         = 6;
   localparam int LONG_HOLD       = 120;
   localparam int FIRST_HOLD_AT   = 300;
   localparam int HOLD_SPACING    = 900;
   localparam int HOLD_COUNT      = 2;
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT  = 2000;

   // The two indexes above the enable register decode to nothing.
   localparam csr_index_type REG_SPARE_LO = REG_ENABLE + 3'd1;
   localparam csr_index_type REG_SPARE_HI = REG_ENABLE + 3'd2;

   typedef enum {RX_PATTERN, RX_ALWAYS} rx_mode_type;
   typedef enum {RX_STEADY, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_style_type;

   logic clock = 1'b0;
   logic reset;

   pctmr_req_if req_bus();
   pctmr_rsp_if rsp_bus();
   pctmr_csr_if csr_bus();

   int        error_count;
   int        pending_results;
   int        checked_results;
   int        match_events;
   int        irq_results;
   count_type predicted_count;

   four_channel_periodic_compare_timer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   compare_timer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .error_count     (error_count),
      .pending_count   (pending_results),
      .checked_count   (checked_results),
      .match_count     (match_events),
      .irq_count       (irq_results),
      .predicted_count (predicted_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The sender works in bursts when tx_bursty is set; burst_left counts the requests that
   // remain before the next gap.
   bit          tx_bursty = 1'b1;
   int          burst_left;
   rx_mode_type rx_mode = RX_PATTERN;

   // Offers one request transaction and returns at the falling edge after it is accepted.
   // Valid is left high so that a following request continues without a bubble; whoever
   // stops sending lowers it.
   task automatic send_tick(input logic tick_in, input chan_mask_type clear_in);
      if (tx_bursty && burst_left == 0) begin
         req_bus.valid      <= 1'b0;
         req_bus.tick       <= 1'($urandom);
         req_bus.flag_clear <= chan_mask_type'($urandom);
         repeat ($urandom_range(1, GAP_MAX)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_bus.valid      <= 1'b1;
      req_bus.tick       <= tick_in;
      req_bus.flag_clear <= clear_in;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Stops offering requests and waits until every predicted response has been seen. It
   // always lets at least one falling edge pass, so valid is never lowered and raised again
   // in the same time step.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
   endtask

   task automatic write_register(input csr_index_type index, input csr_data_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   // Reprograms the timer while it is idle. Only the channels in load_mask get a step
   // write, since a step write also reloads that channel's compare value. Now and then a
   // write goes to one of the undecoded indexes, which the timer must ignore.
   task automatic configure_timer(input count_type prescale,
                                  input logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] steps,
                                  input chan_mask_type load_mask,
                                  input chan_mask_type enable);
      drain_results();
      write_register(REG_PRESCALE, prescale);
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (load_mask[ch]) begin
            write_register(REG_STEP_CH0 + csr_index_type'(ch), steps[ch]);
         end
      end
      if ($urandom_range(0, 1) == 1) begin
         write_register(($urandom_range(0, 1) == 1) ? REG_SPARE_LO : REG_SPARE_HI,
                        csr_data_type'($urandom));
      end
      write_register(REG_ENABLE, csr_data_type'(enable));
      csr_bus.valid <= 1'b0;
   endtask

   // Response side. Outside the long holds it stalls in segments of random length, each
   // with its own pattern. The long holds are triggered by the number of responses seen,
   // which keeps them in the middle of the random traffic; the sender keeps offering
   // requests meanwhile, so the response register fills and the request side stalls.
   rx_style_type rx_style;
   int           rx_segment_left;
   int           rx_cycle;
   int           holds_done;
   int           next_hold_at = FIRST_HOLD_AT;

   always begin
      @(negedge clock);
      if (holds_done < HOLD_COUNT && checked_results >= next_hold_at) begin
         rsp_bus.ready <= 1'b0;
         repeat (LONG_HOLD) @(negedge clock);
         holds_done++;
         next_hold_at += HOLD_SPACING;
      end
      if (rx_mode == RX_ALWAYS) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         if (rx_segment_left == 0) begin
            rx_style        = rx_style_type'($urandom_range(0, 3));
            rx_segment_left = $urandom_range(4, 40);
         end
         rx_segment_left--;
         rx_cycle++;
         case (rx_style)
            RX_STEADY:      rsp_bus.ready <= 1'b1;
            RX_COIN:        rsp_bus.ready <= 1'($urandom);
            RX_EVERY_THIRD: rsp_bus.ready <= (rx_cycle % 3 == 0);
            default:        rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // The watchdog counts cycles in which no transaction moves on any channel.
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] steps;
      count_type     prescale;
      chan_mask_type load_mask;
      chan_mask_type clear_mask;
      int            random_sent;
      int            phase;
      int            phase_len;
      int            pick;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.tick       = 1'b0;
      req_bus.flag_clear = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = REG_PRESCALE;
      csr_bus.data       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Straight after reset: an item without a tick, which must leave the
      // counter alone, then ticks with and without a full clear.
      send_tick(1'b0, '0);
      send_tick(1'b1, '1);
      send_tick(1'b1, '0);

      // Channels 0 and 1 share a compare value so that they match together. Channel 2 is
      // loaded with the current count, which must not set its flag. Channel 3 is disabled:
      // its flag sets on a match but its compare value holds and irq stays low for it.
      steps[0] = 16'd4;
      steps[1] = 16'd4;
      steps[3] = 16'd6;
      drain_results();
      steps[2] = predicted_count;
      configure_timer('0, steps, '1, 4'b0011);
      repeat (5) send_tick(1'b1, '0);
      // This tick clears channels 0 and 1 while they match again: the match wins.
      send_tick(1'b1, 4'b0011);
      send_tick(1'b0, 4'b1000);

      // Let the prescaler run up to two, then lower its limit below that count: the next
      // tick has to treat the count as expired and advance the counter.
      configure_timer(16'd3, steps, '0, 4'b0011);
      repeat (2) send_tick(1'b1, '0);
      configure_timer(16'd1, steps, '0, 4'b0011);
      repeat (2) send_tick(1'b1, '0);
      send_tick(1'b1, '1);

      // Random part, in phases. Each phase reprograms the idle timer; half the step choices
      // put the compare a little ahead of the predicted count so that matches come within
      // the phase, the others use zero, all ones, a random value or channel 0's value.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         drain_results();
         pick = $urandom_range(0, 15);
         if (pick < 9) begin
            prescale = '0;
         end else if (pick < 13) begin
            prescale = count_type'($urandom_range(1, 3));
         end else if (pick == 13) begin
            prescale = COUNT_ALL_ONES;
         end else begin
            prescale = count_type'($urandom);
         end
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            case ($urandom_range(0, 7))
               0:       steps[ch] = '0;
               1:       steps[ch] = COUNT_ALL_ONES;
               2:       steps[ch] = count_type'($urandom);
               3:       steps[ch] = steps[0];
               default: steps[ch] = predicted_count + count_type'($urandom_range(1, 40));
            endcase
         end
         load_mask = ($urandom_range(0, 3) == 0) ? chan_mask_type'($urandom) : '1;
         configure_timer(prescale, steps, load_mask, chan_mask_type'($urandom));

         // Every fifth phase runs with neither side idling.
         tx_bursty = (phase % 5 != 4);
         rx_mode  <= (phase % 5 == 4) ? RX_ALWAYS : RX_PATTERN;
         phase_len = $urandom_range(40, 90);
         for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 7);
            if (pick < 5) begin
               clear_mask = '0;
            end else if (pick == 5) begin
               clear_mask = '1;
            end else begin
               clear_mask = chan_mask_type'($urandom);
            end
            send_tick($urandom_range(0, 9) != 0, clear_mask);
            random_sent++;
            // An occasional pause in which the sender waits for every response.
            if ($urandom_range(0, 59) == 0) begin
               drain_results();
            end
         end
         phase++;
      end

      // Closing pass at full rate with every channel enabled. Channel 0 has a step of zero,
      // so its compare stays at zero; channels 1 to 3 start just ahead of the count and
      // match as the count reaches them, each in a transaction of its own.
      drain_results();
      steps[0] = '0;
      steps[1] = predicted_count + 16'd3;
      steps[2] = predicted_count + 16'd10;
      steps[3] = predicted_count + 16'd25;
      configure_timer('0, steps, '1, '1);
      tx_bursty = 1'b0;
      rx_mode  <= RX_ALWAYS;
      for (int n = 0; n < FINAL_ITEMS; n++) begin
         send_tick(1'b1, ($urandom_range(0, 7) == 0) ? chan_mask_type'($urandom) : '0);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Checked %0d responses over %0d random phases and a closing full-rate pass.",
               checked_results, phase);
      $display("Channel matches seen: %0d; responses with the interrupt raised: %0d.",
               match_events, irq_results);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
